// ===== rtl/pai_pkg.sv =====
// ----------------------------------------------------------------------------
// pai_pkg
// Shared types and codes for the positional insert/delete list block.
// ----------------------------------------------------------------------------
package pai_pkg;

    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_FIX,
        S_LIST,
        S_REPORT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic shift;
        logic fix;
        logic list;
        logic report;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic drained;
        logic fix_empty;
        logic o_ready;
    } dp_stat_t;

endpackage

// ===== rtl/pai_ctrl.sv =====
// ----------------------------------------------------------------------------
// pai_ctrl
// Sequencer for one command: check, shift, fix up, then list or report.
// ----------------------------------------------------------------------------
module pai_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pai_pkg::dp_stat_t stat,
    output pai_pkg::dp_cmd_t  cmd
);
    import pai_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.err ? S_REPORT : S_SHIFT;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.drained) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                cmd.fix    = 1'b1;
                state_next = stat.fix_empty ? S_REPORT : S_LIST;
            end
            S_LIST: begin
                cmd.list = 1'b1;
                if (stat.drained) begin
                    state_next = S_IDLE;
                end
            end
            S_REPORT: begin
                cmd.report = 1'b1;
                if (stat.o_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pai_datapath.sv =====
// ----------------------------------------------------------------------------
// pai_datapath
// List memory, count, move and listing pointers, and the output word register.
// ----------------------------------------------------------------------------
module pai_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pai_pkg::dp_cmd_t                cmd,
    output pai_pkg::dp_stat_t               stat,
    input  logic                            s_command,
    input  logic [pai_pkg::POS_W-1:0]       s_position,
    input  logic signed [pai_pkg::VAL_W-1:0] s_new_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pai_pkg::STAT_W-1:0]      m_status,
    output logic [pai_pkg::POS_W-1:0]       m_entry_count,
    output logic                            m_has_entry,
    output logic [pai_pkg::IDX_W-1:0]       m_entry_index,
    output logic signed [pai_pkg::VAL_W-1:0] m_entry_value,
    output logic                            m_last
);
    import pai_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [POS_W-1:0] CAP_W = POS_W'(CAPACITY);
    localparam logic [POS_W-1:0] ONE   = POS_W'(1);

    logic [VAL_W-1:0] mem [CAPACITY];

    // command word
    logic             op_reg,  op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    status_t          code_reg, code_next;

    // control
    logic [POS_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] ptr_reg,   ptr_next;
    logic [POS_W-1:0] left_reg,  left_next;
    logic [POS_W-1:0] dst_reg,   dst_next;
    logic             pend_reg,  pend_next;
    logic [VAL_W-1:0] rdata_reg;

    // output word
    logic             o_valid_reg, o_valid_next;
    status_t          o_status_reg, o_status_next;
    logic [POS_W-1:0] o_count_reg, o_count_next;
    logic             o_has_reg, o_has_next;
    logic [IDX_W-1:0] o_idx_reg, o_idx_next;
    logic [VAL_W-1:0] o_value_reg, o_value_next;
    logic             o_last_reg, o_last_next;

    logic             o_ready;
    logic             shift_issue;
    logic             list_issue;
    logic             rd_en;
    logic             we;
    logic [POS_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    status_t          err_code;

    assign o_ready     = !o_valid_reg || m_ready;
    assign shift_issue = cmd.shift && (left_reg != '0);
    assign list_issue  = cmd.list && (left_reg != '0) && (!pend_reg || o_ready);
    assign rd_en       = shift_issue || list_issue;

    always_comb begin
        err_code = ST_OK;
        if (op_reg == CMD_INSERT) begin
            if (count_reg >= CAP_W) begin
                err_code = ST_FULL;
            end else if (pos_reg > count_reg) begin
                err_code = ST_BADPOS;
            end
        end else begin
            if (count_reg == '0) begin
                err_code = ST_EMPTY;
            end else if (pos_reg >= count_reg) begin
                err_code = ST_BADPOS;
            end
        end
    end

    assign stat.err       = (err_code != ST_OK);
    assign stat.drained   = (left_reg == '0) && !pend_reg;
    assign stat.fix_empty = (op_reg == CMD_DELETE) && (count_reg == ONE);
    assign stat.o_ready   = o_ready;

    // memory write: moved entry during the shift, new value at fix-up of an insert
    always_comb begin
        we    = 1'b0;
        waddr = dst_reg;
        wdata = rdata_reg;
        if (cmd.shift && pend_reg) begin
            we = 1'b1;
        end else if (cmd.fix && op_reg == CMD_INSERT) begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    always_comb begin
        op_next       = op_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        code_next     = code_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        dst_next      = dst_reg;
        pend_next     = pend_reg;
        o_valid_next  = o_valid_reg && !m_ready;
        o_status_next = o_status_reg;
        o_count_next  = o_count_reg;
        o_has_next    = o_has_reg;
        o_idx_next    = o_idx_reg;
        o_value_next  = o_value_reg;
        o_last_next   = o_last_reg;

        if (cmd.load) begin
            op_next  = s_command;
            pos_next = s_position;
            val_next = s_new_value;
        end

        // set up the move pass; garbage on an error, which skips it
        if (cmd.check) begin
            code_next = err_code;
            pend_next = 1'b0;
            if (op_reg == CMD_INSERT) begin
                ptr_next  = count_reg - ONE;
                left_next = count_reg - pos_reg;
            end else begin
                ptr_next  = pos_reg + ONE;
                left_next = count_reg - pos_reg - ONE;
            end
        end

        if (cmd.shift) begin
            pend_next = shift_issue;
            if (shift_issue) begin
                left_next = left_reg - ONE;
                if (op_reg == CMD_INSERT) begin
                    dst_next = ptr_reg + ONE;
                    ptr_next = ptr_reg - ONE;
                end else begin
                    dst_next = ptr_reg - ONE;
                    ptr_next = ptr_reg + ONE;
                end
            end
        end

        if (cmd.fix) begin
            count_next = (op_reg == CMD_INSERT) ? count_reg + ONE : count_reg - ONE;
            ptr_next   = '0;
            left_next  = count_next;
            pend_next  = 1'b0;
        end

        if (cmd.list) begin
            if (o_ready && pend_reg) begin
                o_valid_next  = 1'b1;
                o_status_next = ST_OK;
                o_count_next  = count_reg;
                o_has_next    = 1'b1;
                o_idx_next    = dst_reg[IDX_W-1:0];
                o_value_next  = rdata_reg;
                o_last_next   = (dst_reg == count_reg - ONE);
            end
            if (list_issue) begin
                pend_next = 1'b1;
                dst_next  = ptr_reg;
                ptr_next  = ptr_reg + ONE;
                left_next = left_reg - ONE;
            end else if (o_ready) begin
                pend_next = 1'b0;
            end
        end

        if (cmd.report && o_ready) begin
            o_valid_next  = 1'b1;
            o_status_next = code_reg;
            o_count_next  = count_reg;
            o_has_next    = 1'b0;
            o_idx_next    = '0;
            o_value_next  = '0;
            o_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        code_reg     <= code_next;
        ptr_reg      <= ptr_next;
        dst_reg      <= dst_next;
        o_status_reg <= o_status_next;
        o_count_reg  <= o_count_next;
        o_has_reg    <= o_has_next;
        o_idx_reg    <= o_idx_next;
        o_value_reg  <= o_value_next;
        o_last_reg   <= o_last_next;
    end

    assign m_valid       = o_valid_reg;
    assign m_status      = o_status_reg;
    assign m_entry_count = o_count_reg;
    assign m_has_entry   = o_has_reg;
    assign m_entry_index = o_idx_reg;
    assign m_entry_value = o_value_reg;
    assign m_last        = o_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_W)
        else $error("entry count above capacity");

    a_shift_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift && pend_reg && shift_issue) |-> (dst_reg != ptr_reg))
        else $error("shift write and read hit the same entry");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (o_valid_reg && o_has_reg) |-> (POS_W'(o_idx_reg) < o_count_reg))
        else $error("listed index beyond entry count");

    a_report_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (o_valid_reg && !o_has_reg) |-> o_last_reg)
        else $error("report word without last");
`endif

endmodule

// ===== rtl/positional_array_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_array_insert_delete
// Ordered list of signed 32-bit values with insert and delete at a position;
// every command answers with the whole list or one status word.
// ----------------------------------------------------------------------------
//  channel | direction | words per command        | payload
//  --------+-----------+--------------------------+-------------------------------
//  s_      | in        | 1                        | command, position, new_value
//  m_      | out       | count, or 1 on error     | status, entry_count, has_entry,
//          |           | or empty list            | entry_index, entry_value, last
//
//  Phases: accept, check, the move pass over the entries that shift, a fix-up
//  that writes an inserted value and updates the count, then the listing. The
//  single memory read port serves both the move pass and the listing. An error
//  goes from the check to one status word; an emptying delete to one word.
//  Reset clears the count and all handshake state; list contents need none.
//  A stall on m_ready holds the output word and pauses the listing.
// ----------------------------------------------------------------------------
module positional_array_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic [pai_pkg::POS_W-1:0]        s_position,
    input  logic signed [pai_pkg::VAL_W-1:0] s_new_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pai_pkg::STAT_W-1:0]       m_status,
    output logic [pai_pkg::POS_W-1:0]        m_entry_count,
    output logic                             m_has_entry,
    output logic [pai_pkg::IDX_W-1:0]        m_entry_index,
    output logic signed [pai_pkg::VAL_W-1:0] m_entry_value,
    output logic                             m_last
);
    import pai_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: take one command word, then walk it through its phases
    pai_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // list memory, pointers and the output word register
    pai_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_command     (s_command),
        .s_position    (s_position),
        .s_new_value   (s_new_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_has_entry   (m_has_entry),
        .m_entry_index (m_entry_index),
        .m_entry_value (m_entry_value),
        .m_last        (m_last)
    );

endmodule

// ===== dv/tb_positional_array_insert_delete.sv =====
// ----------------------------------------------------------------------------
// tb_positional_array_insert_delete
// Self-checking bench for the positional insert/delete list block. A driver
// sends insert and delete commands from a queue filled at time zero, and a
// shadow copy of the list predicts the full listing or status word that each
// accepted command returns. A monitor compares every output word field by
// field. Both channels idle in random bursts except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_positional_array_insert_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import pai_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int RANDOM_CMDS = 230;
    // no idling once fewer than this many commands are left to send
    localparam int QUIET_TAIL  = 40;
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 16;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic                    command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] new_value;
    } list_cmd_t;

    typedef struct {
        status_t                 status;
        logic [POS_W-1:0]        entry_count;
        logic                    has_entry;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic                    last;
    } list_word_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic                    s_command   = CMD_INSERT;
    logic [POS_W-1:0]        s_position  = '0;
    logic signed [VAL_W-1:0] s_new_value = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic [STAT_W-1:0]       m_status;
    logic [POS_W-1:0]        m_entry_count;
    logic                    m_has_entry;
    logic [IDX_W-1:0]        m_entry_index;
    logic signed [VAL_W-1:0] m_entry_value;
    logic                    m_last;

    // commands waiting to be driven, and output words still owed by the block
    list_cmd_t  pending_cmds[$];
    list_word_t listing_words[$];

    // shadow of the list as the block should hold it
    logic signed [VAL_W-1:0] shadow_list [CAPACITY];
    int                      shadow_len;

    // count the stimulus generator expects, used only to pick sensible positions
    int plan_len;

    int mismatch_cnt;
    int cycle_cnt;
    int send_gap;
    int stall_left;

    positional_array_insert_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_position   (s_position),
        .s_new_value  (s_new_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_entry_count(m_entry_count),
        .m_has_entry  (m_has_entry),
        .m_entry_index(m_entry_index),
        .m_entry_value(m_entry_value),
        .m_last       (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Append one expected output word; the count field is taken after the update.
    task automatic push_word(input status_t st, input logic has, input int idx,
                             input logic signed [VAL_W-1:0] val, input logic lst);
        list_word_t w;
        w.status      = st;
        w.entry_count = shadow_len[POS_W-1:0];
        w.has_entry   = has;
        w.entry_index = idx[IDX_W-1:0];
        w.entry_value = val;
        w.last        = lst;
        listing_words.push_back(w);
    endtask

    // Apply one accepted command to the shadow list and queue the words it
    // causes: the whole list, a single empty-list word, or one status word.
    task automatic predict_listing(input logic cmd, input logic [POS_W-1:0] pos,
                                   input logic signed [VAL_W-1:0] val);
        status_t st;
        int      i;
        st = ST_OK;
        if (cmd == CMD_INSERT) begin
            // the full check wins over the position check
            if (shadow_len >= CAPACITY) begin
                st = ST_FULL;
            end else if (int'(pos) > shadow_len) begin
                st = ST_BADPOS;
            end else begin
                for (i = shadow_len; i > int'(pos); i--)
                    shadow_list[i] = shadow_list[i-1];
                shadow_list[pos] = val;
                shadow_len++;
            end
        end else begin
            // the empty check wins over the position check
            if (shadow_len == 0) begin
                st = ST_EMPTY;
            end else if (int'(pos) >= shadow_len) begin
                st = ST_BADPOS;
            end else begin
                for (i = int'(pos); i + 1 < shadow_len; i++)
                    shadow_list[i] = shadow_list[i+1];
                shadow_len--;
            end
        end
        if (st != ST_OK || shadow_len == 0) begin
            push_word(st, 1'b0, 0, '0, 1'b1);
        end else begin
            for (i = 0; i < shadow_len; i++)
                push_word(ST_OK, 1'b1, i, shadow_list[i], i == shadow_len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    // Queue a command and track the count it should leave behind.
    task automatic queue_command(input logic cmd, input int pos,
                                 input logic signed [VAL_W-1:0] val);
        list_cmd_t c;
        c.command   = cmd;
        c.position  = pos[POS_W-1:0];
        c.new_value = val;
        pending_cmds.push_back(c);
        if (cmd == CMD_INSERT && plan_len < CAPACITY && pos <= plan_len)
            plan_len++;
        else if (cmd == CMD_DELETE && plan_len > 0 && pos < plan_len)
            plan_len--;
    endtask

    // Bias values toward the signed extremes and small numbers.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $urandom_range(0, 15);
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Pick a legal position for the planned count; at full or empty this
    // still lands on the full or empty status, which is wanted.
    function automatic int legal_position(input logic cmd);
        if (cmd == CMD_INSERT)
            return $urandom_range(0, plan_len);
        if (plan_len == 0)
            return 0;
        return $urandom_range(0, plan_len - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present one word at a time, hold it until accepted, then
    // optionally idle for a short burst before the next one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_commands
        list_cmd_t nxt;
        logic      take;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            take = s_valid && s_ready;
            if (take)
                predict_listing(s_command, s_position, s_new_value);
            if (!s_valid || take) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    s_valid     <= 1'b1;
                    s_command   <= nxt.command;
                    s_position  <= nxt.position;
                    s_new_value <= nxt.new_value;
                    // schedule an idle burst after this word, except in the tail
                    if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure: drop ready now and then, for a burst of random length.
    // No stalls start while bits 9:8 of cycle_cnt are both set, and the tail runs clean.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (pending_cmds.size() >= QUIET_TAIL && cycle_cnt[9:8] != 2'b11 &&
                     $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] mismatch %0d: %s", $realtime, mismatch_cnt, what);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted output word with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_words
        list_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (listing_words.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected word st=%0d cnt=%0d has=%0b idx=%0d val=%0d last=%0b",
                    m_status, m_entry_count, m_has_entry, m_entry_index,
                    m_entry_value, m_last));
            end else begin
                want = listing_words.pop_front();
                if (m_status !== want.status || m_entry_count !== want.entry_count ||
                    m_has_entry !== want.has_entry || m_entry_index !== want.entry_index ||
                    m_entry_value !== want.entry_value || m_last !== want.last) begin
                    report_mismatch($sformatf({
                        "exp st=%0d cnt=%0d has=%0b idx=%0d val=%0d last=%0b",
                        " got st=%0d cnt=%0d has=%0b idx=%0d val=%0d last=%0b"},
                        want.status, want.entry_count, want.has_entry,
                        want.entry_index, want.entry_value, want.last,
                        m_status, m_entry_count, m_has_entry, m_entry_index,
                        m_entry_value, m_last));
                end
            end
        end
    end

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL positional_array_insert_delete");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the stimulus, release reset, wait for the drain.
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        int  rand_cnt;
        int  seg_mode;
        int  seg_len;
        int  k;
        logic cmd;

        shadow_len   = 0;
        plan_len     = 0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        foreach (shadow_list[i])
            shadow_list[i] = '0;

        // Directed: errors on the empty list, both list ends, signed extremes,
        // and a delete that empties the list.
        queue_command(CMD_DELETE, 0, 32'sd0);           // delete from empty
        queue_command(CMD_DELETE, 127, 32'sd9);         // empty wins over position
        queue_command(CMD_INSERT, 1, 32'sd5);           // insert past count
        queue_command(CMD_INSERT, 127, -32'sd1);        // insert far past count
        queue_command(CMD_INSERT, 0, 32'sh7FFF_FFFF);
        queue_command(CMD_INSERT, 0, 32'sh8000_0000);   // insert at head
        queue_command(CMD_INSERT, 2, -32'sd1);          // insert at tail
        queue_command(CMD_INSERT, 1, 32'sd0);           // insert in the middle
        queue_command(CMD_INSERT, 4, 32'sh5555_AAAA);
        queue_command(CMD_DELETE, 5, 32'sd0);           // delete at count
        queue_command(CMD_DELETE, 64, 32'sd0);          // delete far past count
        queue_command(CMD_DELETE, 4, 32'sd0);           // delete the tail
        queue_command(CMD_DELETE, 0, 32'sd0);           // delete the head
        queue_command(CMD_DELETE, 1, 32'sd0);           // delete in the middle
        queue_command(CMD_DELETE, 0, 32'sd0);
        queue_command(CMD_DELETE, 0, 32'sd0);           // list becomes empty
        queue_command(CMD_DELETE, 0, 32'sd0);

        // Fill to capacity, poke the full list, then drain it completely.
        rand_cnt = pending_cmds.size();
        while (plan_len < CAPACITY) begin
            queue_command(CMD_INSERT, legal_position(CMD_INSERT), pick_value());
            rand_cnt++;
        end
        queue_command(CMD_INSERT, CAPACITY, pick_value());
        queue_command(CMD_INSERT, $urandom_range(CAPACITY + 1, 127), pick_value());
        queue_command(CMD_INSERT, $urandom_range(0, CAPACITY - 1), pick_value());
        rand_cnt += 3;
        while (plan_len > 0) begin
            queue_command(CMD_DELETE, legal_position(CMD_DELETE), $urandom);
            rand_cnt++;
        end

        // Random segments: filling, draining or balanced, mostly legal
        // positions with some noise anywhere in the position range.
        while (rand_cnt < RANDOM_CMDS) begin
            seg_mode = $urandom_range(0, 2);
            seg_len  = $urandom_range(8, 40);
            for (k = 0; k < seg_len && rand_cnt < RANDOM_CMDS; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    cmd = 1'($urandom_range(0, 1));
                    queue_command(cmd, $urandom_range(0, 127), $urandom);
                end else begin
                    case (seg_mode)
                        0:       cmd = ($urandom_range(0, 9) < 8) ? CMD_INSERT : CMD_DELETE;
                        1:       cmd = ($urandom_range(0, 9) < 8) ? CMD_DELETE : CMD_INSERT;
                        default: cmd = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_DELETE;
                    endcase
                    queue_command(cmd, legal_position(cmd), pick_value());
                end
                rand_cnt++;
            end
        end

        // Hold reset low, then release it.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Wait for every command to be accepted and every word to arrive,
        // then give the block time to show any stray words.
        while (pending_cmds.size() != 0 || s_valid)
            @(posedge aclk);
        while (listing_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (listing_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", listing_words.size()));
        if (mismatch_cnt == 0) begin
            $display("PASS positional_array_insert_delete");
        end else begin
            $display("FAIL positional_array_insert_delete");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pai_pkg.sv
rtl/pai_ctrl.sv
rtl/pai_datapath.sv
rtl/positional_array_insert_delete.sv
dv/tb_positional_array_insert_delete.sv
